### rtl/core/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared types and constants for the two-priority sprite list stager.
// ----------------------------------------------------------------------------
package tpss_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int ENTRY_W       = 48;
  localparam int WORD_W        = 16;
  localparam int SLOT_W        = 6;
  localparam int S_TDATA_W     = 48;
  localparam int S_TUSER_W     = 2;
  localparam int M_TDATA_W     = 56;
  localparam int M_TUSER_W     = 2;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [WORD_W-1:0] HIDE_Y_RESET = 16'd480;

  // register index taken from paddr[2]
  localparam logic REG_HIDE_Y = 1'b0;

  typedef enum logic [1:0] {
    ACT_LOW    = 2'd0,
    ACT_HIGH   = 2'd1,
    ACT_UPLOAD = 2'd2
  } action_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPLOAD
  } seq_state_t;

  typedef struct packed {
    logic filler;
    logic ovf;
    logic last;
  } slot_flags_t;

endpackage

### rtl/core/tpss_store.sv
// ----------------------------------------------------------------------------
// tpss_store
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tpss_store #(
  parameter int DEPTH = tpss_pkg::SLOTS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [tpss_pkg::ENTRY_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [tpss_pkg::ENTRY_W-1:0] rdata
);
  import tpss_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/tpss_cfg.sv
// ----------------------------------------------------------------------------
// tpss_cfg
// APB register file holding the filler Y coordinate.
// ----------------------------------------------------------------------------
module tpss_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpss_pkg::PADDR_W-1:0]  paddr,
  input  logic [tpss_pkg::PDATA_W-1:0]  pwdata,
  output logic [tpss_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [tpss_pkg::WORD_W-1:0]   hide_y
);
  import tpss_pkg::*;

  logic wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hide_y <= HIDE_Y_RESET;
    end else if (wr_fire && (paddr[2] == REG_HIDE_Y)) begin
      hide_y <= pwdata[WORD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_HIDE_Y) begin
      prdata = {{(PDATA_W-WORD_W){1'b0}}, hide_y};
    end else begin
      prdata = '0;
    end
  end

endmodule

### rtl/core/tpss_seq.sv
// ----------------------------------------------------------------------------
// tpss_seq
// List counters, upload sequencer, read stage and output register.
// ----------------------------------------------------------------------------
module tpss_seq #(
  parameter int SLOTS = tpss_pkg::SLOTS_DEFAULT,
  localparam int AW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tpss_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [tpss_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tpss_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [tpss_pkg::M_TUSER_W-1:0] m_tuser,
  output logic                           m_tlast,
  input  logic [tpss_pkg::WORD_W-1:0]    hide_y,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output logic [tpss_pkg::ENTRY_W-1:0]   mem_wdata,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_raddr,
  input  logic [tpss_pkg::ENTRY_W-1:0]   mem_rdata
);
  import tpss_pkg::*;

  seq_state_t state, state_next;

  logic [CW-1:0] low_count, high_count;
  logic [CW-1:0] run_low, run_high;
  logic          overflow_flag, run_ovf;
  logic [AW-1:0] t;

  logic          in_fire, is_append, full, issue, out_free, t_last;
  logic          in_low, in_high;
  logic [CW:0]   sum;
  logic [CW-1:0] t_ext, d;
  action_t       act;

  logic          s1_valid;
  logic [AW-1:0] s1_slot;
  slot_flags_t   s1_flags;

  logic [AW-1:0]      out_slot;
  logic [ENTRY_W-1:0] out_entry;
  slot_flags_t        out_flags;

  assign act       = action_t'(s_tuser);
  assign in_fire   = s_tvalid && s_tready;
  assign is_append = (act == ACT_LOW) || (act == ACT_HIGH);
  assign sum       = {1'b0, low_count} + {1'b0, high_count};
  assign full      = sum >= (CW + 1)'(SLOTS);
  assign out_free  = !m_tvalid || m_tready;
  assign t_last    = t == AW'(SLOTS - 1);

  // append write path
  assign mem_we    = in_fire && is_append && !full;
  assign mem_wdata = s_tdata[ENTRY_W-1:0];
  assign mem_waddr = (act == ACT_LOW) ? low_count[AW-1:0]
                                      : AW'(SLOTS - 1) - high_count[AW-1:0];

  // upload source slot
  assign t_ext     = CW'(t);
  assign d         = t_ext - run_low;
  assign in_low    = t_ext < run_low;
  assign in_high   = !in_low && (d < run_high);
  assign mem_raddr = in_low ? t : AW'(SLOTS - 1) - d[AW-1:0];
  assign mem_re    = issue;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && (act == ACT_UPLOAD)) begin
          state_next = ST_UPLOAD;
        end
      end
      ST_UPLOAD: begin
        if (issue && t_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_UPLOAD: issue = !s1_valid || out_free;
      default: begin
        s_tready = 1'b0;
        issue    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // list counters and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      low_count     <= '0;
      high_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (in_fire) begin
      unique case (act)
        ACT_LOW: begin
          if (full) begin
            overflow_flag <= 1'b1;
          end else begin
            low_count <= low_count + CW'(1);
          end
        end
        ACT_HIGH: begin
          if (full) begin
            overflow_flag <= 1'b1;
          end else begin
            high_count <= high_count + CW'(1);
          end
        end
        ACT_UPLOAD: begin
          low_count     <= '0;
          high_count    <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // snapshot of the lists for the run
  always_ff @(posedge clk) begin
    if (in_fire && (act == ACT_UPLOAD)) begin
      run_low  <= low_count;
      run_high <= high_count;
      run_ovf  <= overflow_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t <= '0;
    end else if (in_fire && (act == ACT_UPLOAD)) begin
      t <= '0;
    end else if (issue) begin
      t <= t + AW'(1);
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (issue) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_slot         <= t;
      s1_flags.filler <= !in_low && !in_high;
      s1_flags.ovf    <= run_ovf;
      s1_flags.last   <= t_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      out_slot  <= s1_slot;
      out_flags <= s1_flags;
      if (s1_flags.filler) begin
        out_entry <= {{WORD_W{1'b0}}, hide_y, {WORD_W{1'b0}}};
      end else begin
        out_entry <= mem_rdata;
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W-ENTRY_W-SLOT_W){1'b0}}, out_entry, SLOT_W'(out_slot)};
  assign m_tuser = {out_flags.ovf, out_flags.filler};
  assign m_tlast = out_flags.last;

endmodule

### rtl/core/two_priority_sprite_list_stager.sv
// ----------------------------------------------------------------------------
// two_priority_sprite_list_stager
// Stages sprite entries in two priority lists and uploads a full table.
// ----------------------------------------------------------------------------
// Input stream: s_tuser carries the action (append low, append high, upload),
// s_tdata carries the entry words x, y, tile. Appends are taken one per cycle
// while no upload runs and write one store entry each; they produce no output.
// A full store drops the append and sets a sticky overflow flag.
// An upload produces SLOTS output transactions, one per cycle while m_tready
// is high: low entries in write order, high entries in write order, then
// filler entries (0, hide_y, 0). After the upload is accepted, the first output
// passes the upload state, the store read and the output register.
// The input side is held off while the run's reads issue, paced by the single
// store read port; appends are accepted again once the last read has issued.
// A stalled receiver holds the output register and the read stage; reads
// resume when it takes data. hide_y is written over the APB port.
// Reset clears the lists, the overflow flag and the stream valids and sets
// hide_y to 480; the store contents are not cleared, no output uses them
// before they are written.
// ----------------------------------------------------------------------------
module two_priority_sprite_list_stager #(
  parameter int SLOTS = tpss_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tpss_pkg::S_TDATA_W-1:0] s_tdata,  // sprite_x, sprite_y, sprite_tile
  input  logic [tpss_pkg::S_TUSER_W-1:0] s_tuser,  // action
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [tpss_pkg::M_TDATA_W-1:0] m_tdata,  // table_slot, out_x, out_y, out_tile
  output logic [tpss_pkg::M_TUSER_W-1:0] m_tuser,  // is_filler, overflowed
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpss_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpss_pkg::PDATA_W-1:0]   pwdata,
  output logic [tpss_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import tpss_pkg::*;

  localparam int AW = $clog2(SLOTS);

  logic [WORD_W-1:0]  hide_y;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

  tpss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hide_y  (hide_y)
  );

  tpss_store #(
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tpss_seq #(
    .SLOTS (SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .hide_y    (hide_y),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

### rtl/core/tpss_checker.sv
// ----------------------------------------------------------------------------
// tpss_checker
// Port-level checks on the output stream of the sprite list stager.
// ----------------------------------------------------------------------------
module tpss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tpss_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [tpss_pkg::M_TUSER_W-1:0] m_tuser,
  input logic                           m_tlast
);
  import tpss_pkg::*;

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast)))
    else $error("stalled output transaction changed");

  // table slots count up within a run
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (!m_tvalid || (m_tdata[5:0] == 6'($past(m_tdata[5:0]) + 6'd1))))
    else $error("table slot did not advance");

  // a new run starts at slot zero
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tdata[5:0] == 6'd0)))
    else $error("run did not start at slot zero");

  // filler entries carry zero x and tile words
  a_filler: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> ((m_tdata[21:6] == 16'd0) && (m_tdata[53:38] == 16'd0)))
    else $error("filler entry with nonzero words");

endmodule

bind two_priority_sprite_list_stager tpss_checker u_tpss_checker (.*);
